>>> sv/rzad_pkg.sv
// Package: shared types, codes and constants of the rolling z-score detector.
package rzad_pkg;

    // Default window depth and the minimum number of held samples for statistics
    localparam int WINDOW_DEPTH_DEF = 16;
    localparam int MIN_SAMPLES      = 5;

    // Configuration register indexes
    localparam logic [7:0] REG_RULE_ENABLE   = 8'd0;
    localparam logic [7:0] REG_RULE_LIMIT    = 8'd1;
    localparam logic [7:0] REG_Z_THRESHOLD   = 8'd2;
    localparam logic [7:0] REG_MIN_DEVIATION = 8'd3;

    // Reset values of the configuration registers
    localparam logic [7:0]  RULE_LIMIT_RST    = 8'd100;
    localparam logic [15:0] Z_THRESHOLD_RST   = 16'd768;
    localparam logic [15:0] MIN_DEVIATION_RST = 16'd128;

    // Reason codes
    localparam logic [1:0] RC_STABLE = 2'd0;
    localparam logic [1:0] RC_BREACH = 2'd1;
    localparam logic [1:0] RC_STAT   = 2'd2;

    typedef struct packed {
        logic [15:0] load_sample;
    } t_sample;

    typedef struct packed {
        logic        anomaly;
        logic [1:0]  reason_code;
        logic [15:0] z_value;
    } t_result;

    typedef struct packed {
        logic [7:0]  index;
        logic [15:0] value;
    } t_cfg;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_MUL_SS,
        OP_MUL_NX,
        OP_MUL_FD,
        OP_DIFF,
        OP_SQRT,
        OP_DIV_INIT,
        OP_DIV,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic breach;
        logic few;
    } t_sts;

endpackage

>>> sv/rzad_stream_if.sv
// Interface: valid/ready channel carrying one payload item.
interface rzad_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rzad_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module rzad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read ports
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/rzad_ctrl.sv
// Controller: sequences window sums, products, square root and division per item.
module rzad_ctrl #(
    parameter int WINDOW_DEPTH = rzad_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  rzad_pkg::t_sts                  i_sts,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] i_last_idx,
    output rzad_pkg::t_cmd                  o_cmd,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_rd_addr
);
    localparam int NW   = $clog2(WINDOW_DEPTH + 1);
    localparam int IDXW = $clog2(WINDOW_DEPTH);
    localparam int SW   = 16 + NW;
    localparam int DVW  = SW + 8;
    localparam int STW  = $clog2(DVW + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_READ, S_DRAIN, S_MUL_LO, S_MUL_HI, S_MUL_SS,
        S_MUL_NX, S_MUL_FD, S_DIFF, S_SQRT, S_DIV_INIT, S_DIV, S_FINISH
    } t_state;

    t_state          r_state;
    logic [IDXW-1:0] r_idx;
    logic [STW-1:0]  r_step;
    logic [1:0]      r_kind;
    logic            r_out_valid;
    logic            w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_rd_addr   = r_idx;

    // Decode the datapath operation from the state
    always_comb begin
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE:     o_cmd.op = i_in_valid ? rzad_pkg::OP_LOAD : rzad_pkg::OP_NONE;
            S_READ:     o_cmd.op = rzad_pkg::OP_READ;
            S_MUL_LO:   o_cmd.op = rzad_pkg::OP_MUL_LO;
            S_MUL_HI:   o_cmd.op = rzad_pkg::OP_MUL_HI;
            S_MUL_SS:   o_cmd.op = rzad_pkg::OP_MUL_SS;
            S_MUL_NX:   o_cmd.op = rzad_pkg::OP_MUL_NX;
            S_MUL_FD:   o_cmd.op = rzad_pkg::OP_MUL_FD;
            S_DIFF:     o_cmd.op = rzad_pkg::OP_DIFF;
            S_SQRT:     o_cmd.op = rzad_pkg::OP_SQRT;
            S_DIV_INIT: o_cmd.op = rzad_pkg::OP_DIV_INIT;
            S_DIV:      o_cmd.op = rzad_pkg::OP_DIV;
            S_FINISH:   o_cmd.op = w_out_free ? rzad_pkg::OP_FINISH : rzad_pkg::OP_NONE;
            default:    o_cmd.op = rzad_pkg::OP_NONE;
        endcase
    end

    // State, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_step      <= '0;
            r_kind      <= rzad_pkg::RC_STABLE;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on a finished item, drop it once taken
            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_idx <= '0;
                    priority if (i_sts.breach) begin
                        r_kind  <= rzad_pkg::RC_BREACH;
                        r_state <= S_FINISH;
                    end else if (i_sts.few) begin
                        r_kind  <= rzad_pkg::RC_STABLE;
                        r_state <= S_FINISH;
                    end else begin
                        r_kind  <= rzad_pkg::RC_STAT;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (r_idx == i_last_idx) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN:  r_state <= S_MUL_LO;
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_MUL_SS;
                S_MUL_SS: r_state <= S_MUL_NX;
                S_MUL_NX: r_state <= S_MUL_FD;
                S_MUL_FD: r_state <= S_DIFF;
                S_DIFF: begin
                    r_step  <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (r_step == STW'(SW - 1)) begin
                        r_state <= S_DIV_INIT;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_DIV_INIT: begin
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == STW'(DVW - 1)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/rzad_dp.sv
// Datapath: configuration, sample ring, accumulators, square root and divider.
module rzad_dp #(
    parameter int WINDOW_DEPTH = rzad_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rzad_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(WINDOW_DEPTH)-1:0] i_rd_addr,
    input  rzad_pkg::t_sample               i_sample,
    input  logic                            i_cfg_we,
    input  rzad_pkg::t_cfg                  i_cfg,
    output rzad_pkg::t_sts                  o_sts,
    output logic [$clog2(WINDOW_DEPTH)-1:0] o_last_idx,
    output rzad_pkg::t_result               o_result
);
    localparam int NW   = $clog2(WINDOW_DEPTH + 1);
    localparam int IDXW = $clog2(WINDOW_DEPTH);
    localparam int SW   = 16 + NW;
    localparam int QW   = 32 + NW;
    localparam int QL   = QW / 2;
    localparam int QH   = QW - QL;
    localparam int VW   = 2 * SW;
    localparam int DVW  = SW + 8;

    // Configuration registers
    logic        r_rule_enable;
    logic [7:0]  r_rule_limit;
    logic [15:0] r_z_threshold;
    logic [15:0] r_min_deviation;

    // Window state and item registers
    logic [NW-1:0]   r_fill;
    logic [IDXW-1:0] r_wp;
    logic [15:0]     r_x;
    logic            r_rd_vld;
    logic [15:0]     w_rd_data;
    logic [SW-1:0]   r_s;
    logic [QW-1:0]   r_q;
    logic [VW-1:0]   r_nq;
    logic [VW-1:0]   r_ss;
    logic [SW-1:0]   r_nx;
    logic [SW-1:0]   r_fd;
    logic [VW-1:0]   r_v;
    logic [VW-1:0]   r_res;
    logic [VW-1:0]   r_bit;
    logic [SW-1:0]   r_num;
    logic [SW-1:0]   r_d;
    logic [SW-1:0]   r_rem;
    logic [DVW-1:0]  r_dvd;
    logic [DVW-1:0]  r_quo;
    rzad_pkg::t_result r_out;

    logic            w_push;
    logic [15:0]     w_md;
    logic [31:0]     w_sq;
    logic [NW+QL-1:0] w_plo;
    logic [NW+QH-1:0] w_phi;
    logic [VW-1:0]   w_t;
    logic [SW:0]     w_r;
    logic [15:0]     w_z;

    assign w_push = (i_cmd.op == rzad_pkg::OP_FINISH);

    rzad_ram #(
        .WIDTH (16),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_wp),
        .i_wdata (r_x),
        .i_re    (i_cmd.op == rzad_pkg::OP_READ),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rd_data)
    );

    // Status toward the controller
    assign o_sts.breach = r_rule_enable && (r_x > {r_rule_limit, 8'h00});
    assign o_sts.few    = (r_fill < NW'(rzad_pkg::MIN_SAMPLES));
    assign o_last_idx   = IDXW'(r_fill - 1'b1);
    assign o_result     = r_out;

    // Arithmetic helpers
    assign w_md  = (r_min_deviation == 16'd0) ? 16'd1 : r_min_deviation;
    assign w_sq  = w_rd_data * w_rd_data;
    assign w_plo = r_fill * r_q[QL-1:0];
    assign w_phi = r_fill * r_q[QW-1:QL];
    assign w_t   = r_res + r_bit;
    assign w_r   = {r_rem, r_dvd[DVW-1]};
    assign w_z   = (|r_quo[DVW-1:16]) ? 16'hFFFF : r_quo[15:0];

    // Configuration and window pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_enable   <= 1'b0;
            r_rule_limit    <= rzad_pkg::RULE_LIMIT_RST;
            r_z_threshold   <= rzad_pkg::Z_THRESHOLD_RST;
            r_min_deviation <= rzad_pkg::MIN_DEVIATION_RST;
            r_fill          <= '0;
            r_wp            <= '0;
            r_rd_vld        <= 1'b0;
        end else begin
            r_rd_vld <= (i_cmd.op == rzad_pkg::OP_READ);
            if (i_cfg_we) begin
                if (i_cfg.index == rzad_pkg::REG_RULE_ENABLE) begin
                    r_rule_enable <= i_cfg.value[0];
                end
                if (i_cfg.index == rzad_pkg::REG_RULE_LIMIT) begin
                    r_rule_limit <= i_cfg.value[7:0];
                end
                if (i_cfg.index == rzad_pkg::REG_Z_THRESHOLD) begin
                    r_z_threshold <= i_cfg.value;
                end
                if (i_cfg.index == rzad_pkg::REG_MIN_DEVIATION) begin
                    r_min_deviation <= i_cfg.value;
                end
            end
            if (w_push) begin
                r_wp <= (r_wp == IDXW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != NW'(WINDOW_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    // Accumulate, multiply, root, divide and form the result
    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_s <= r_s + SW'(w_rd_data);
            r_q <= r_q + QW'(w_sq);
        end
        unique case (i_cmd.op)
            rzad_pkg::OP_LOAD: begin
                r_x <= i_sample.load_sample;
                r_s <= '0;
                r_q <= '0;
            end
            rzad_pkg::OP_MUL_LO: r_nq <= VW'(w_plo);
            rzad_pkg::OP_MUL_HI: r_nq <= r_nq + (VW'(w_phi) << QL);
            rzad_pkg::OP_MUL_SS: r_ss <= r_s * r_s;
            rzad_pkg::OP_MUL_NX: r_nx <= r_fill * r_x;
            rzad_pkg::OP_MUL_FD: r_fd <= r_fill * w_md;
            rzad_pkg::OP_DIFF: begin
                r_v   <= r_nq - r_ss;
                r_num <= (r_nx >= r_s) ? (r_nx - r_s) : (r_s - r_nx);
                r_res <= '0;
                r_bit <= VW'(1) << (VW - 2);
            end
            rzad_pkg::OP_SQRT: begin
                if (r_v >= w_t) begin
                    r_v   <= r_v - w_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            rzad_pkg::OP_DIV_INIT: begin
                r_d   <= (r_res[SW-1:0] > r_fd) ? r_res[SW-1:0] : r_fd;
                r_rem <= '0;
                r_dvd <= {r_num, 8'h00};
                r_quo <= '0;
            end
            rzad_pkg::OP_DIV: begin
                if (w_r >= {1'b0, r_d}) begin
                    r_rem <= SW'(w_r - {1'b0, r_d});
                    r_quo <= {r_quo[DVW-2:0], 1'b1};
                end else begin
                    r_rem <= w_r[SW-1:0];
                    r_quo <= {r_quo[DVW-2:0], 1'b0};
                end
                r_dvd <= r_dvd << 1;
            end
            rzad_pkg::OP_FINISH: begin
                priority if (i_cmd.kind == rzad_pkg::RC_BREACH) begin
                    r_out.anomaly     <= 1'b1;
                    r_out.reason_code <= rzad_pkg::RC_BREACH;
                    r_out.z_value     <= 16'd0;
                end else if (i_cmd.kind == rzad_pkg::RC_STAT) begin
                    r_out.anomaly     <= (w_z > r_z_threshold);
                    r_out.reason_code <= (w_z > r_z_threshold) ? rzad_pkg::RC_STAT
                                                               : rzad_pkg::RC_STABLE;
                    r_out.z_value     <= w_z;
                end else begin
                    r_out.anomaly     <= 1'b0;
                    r_out.reason_code <= rzad_pkg::RC_STABLE;
                    r_out.z_value     <= 16'd0;
                end
            end
            default: ;
        endcase
    end
endmodule

>>> sv/rolling_zscore_anomaly_detector_unit.sv
// Top level: rolling z-score anomaly detector, controller plus datapath.
//
//  Channel    Dir  Payload                               Accepted when
//  i_sample   in   load_sample[15:0]                     valid & ready
//  o_result   out  anomaly, reason_code[1:0], z_value    valid & ready
//  i_cfg      in   index[7:0], value[15:0]               valid & ready (ready tied high)
//
// One item at a time. A rule breach or a window of fewer than five samples goes
// straight to the result; a statistical check reads the held samples through the ring
// RAM port, then runs the products, the bit-serial root and the divider.
// Synchronous active-low reset clears control, pointers and configuration registers;
// the ring itself and the arithmetic and result registers are not cleared. A held
// result does not block the next item until it ends.
module rolling_zscore_anomaly_detector_unit #(
    parameter int WINDOW_DEPTH = rzad_pkg::WINDOW_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rzad_stream_if.sink   i_sample,
    rzad_stream_if.source o_result,
    rzad_stream_if.sink   i_cfg
);
    localparam int IDXW = $clog2(WINDOW_DEPTH);

    rzad_pkg::t_cmd    w_cmd;
    rzad_pkg::t_sts    w_sts;
    rzad_pkg::t_result w_result;
    logic [IDXW-1:0]   w_rd_addr;
    logic [IDXW-1:0]   w_last_idx;

    assign i_cfg.ready = 1'b1;

    rzad_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample.valid),
        .o_in_ready  (i_sample.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (w_sts),
        .i_last_idx  (w_last_idx),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    rzad_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_rd_addr  (w_rd_addr),
        .i_sample   (i_sample.data),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg      (i_cfg.data),
        .o_sts      (w_sts),
        .o_last_idx (w_last_idx),
        .o_result   (w_result)
    );

    assign o_result.data = w_result;

    // Result fields agree with each other
    a_flag_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |->
            (o_result.data.anomaly == (o_result.data.reason_code != rzad_pkg::RC_STABLE)))
        else $error("anomaly flag disagrees with reason code");

    a_breach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.data.reason_code == rzad_pkg::RC_BREACH) |->
            (o_result.data.z_value == 16'd0))
        else $error("rule breach carries a z-score");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_sample.valid && i_sample.ready) |=> !i_sample.ready)
        else $error("second item taken while one is in work");
endmodule
